// ===== rtl/csu_pkg.sv =====
// Shared types and constants for the cosine similarity unit.
`timescale 1ns / 1ps
package csu_pkg;
    localparam int ElemW = 8;
    localparam int SimW  = 16;
    localparam int RBits = 16;                 // magnitude bits resolved by the search
    localparam int CntW  = 5;

    // Controller to datapath commands
    typedef struct packed {
        logic start;      // latch the finished sums, begin the search
        logic bit_step;   // multiply stage: square the trial value
        logic lo_step;    // multiply the trial square into the low half of na*nb
        logic hi_step;    // add in the high half of na*nb
        logic cmp_step;   // compare stage: decide one result bit
        logic finish;     // form the result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic zero;       // either norm was zero
    } t_dp_stat;
endpackage

// ===== rtl/csu_datapath.sv =====
// Accumulators and the bit-serial rounding search for the cosine similarity unit.
`timescale 1ns / 1ps
module csu_datapath #(
    parameter int AccW  = 25,
    parameter int NormW = 24,
    parameter int AccLim = 8388608
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_acc_en,
    input  logic                               i_acc_last,
    input  logic signed [csu_pkg::ElemW-1:0]   i_a,
    input  logic signed [csu_pkg::ElemW-1:0]   i_b,
    input  csu_pkg::t_dp_cmd                   i_cmd,
    input  logic [csu_pkg::CntW-1:0]           i_bit,
    output csu_pkg::t_dp_stat                  o_stat,
    output logic signed [csu_pkg::SimW-1:0]    o_sim
);
    localparam int PW = 2 * NormW;
    localparam int LW = AccW + 16;           // |dot| << 16
    localparam int SW = 2 * LW;              // square of lhs
    localparam int TW = 2 * csu_pkg::RBits + 2; // (2r-1)^2
    localparam int QW = TW + PW;
    localparam logic signed [AccW+1:0] LimS = (AccW+2)'(AccLim);
    localparam int SimW_L = csu_pkg::SimW;

    logic signed [AccW-1:0] r_dot;
    logic [NormW-1:0] r_na, r_nb;
    logic signed [AccW+1:0] n_dot, n_na, n_nb;
    logic signed [15:0] w_ab, w_aa, w_bb;

    assign w_ab = i_a * i_b;
    assign w_aa = i_a * i_a;
    assign w_bb = i_b * i_b;

    function automatic logic signed [AccW+1:0] sat(input logic signed [AccW+1:0] v);
        if (v > LimS) return LimS;
        if (v < -LimS) return -LimS;
        return v;
    endfunction

    always_comb begin
        n_dot = sat((AccW+2)'(r_dot) + (AccW+2)'(w_ab));
        n_na  = sat($signed({3'b0, r_na}) + (AccW+2)'(w_aa));
        n_nb  = sat($signed({3'b0, r_nb}) + (AccW+2)'(w_bb));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0; r_na <= '0; r_nb <= '0;
        end else if (i_acc_en) begin
            if (i_acc_last) begin
                r_dot <= '0; r_na <= '0; r_nb <= '0;
            end else begin
                r_dot <= n_dot[AccW-1:0];
                r_na  <= n_na[NormW-1:0];
                r_nb  <= n_nb[NormW-1:0];
            end
        end
    end

    // Snapshot of the finished vector, consumed by the search; input is held off until the result is taken.
    logic [NormW-1:0] r_sa, r_sb;
    logic [AccW-1:0] r_mag;
    logic r_neg, r_zero;
    logic [PW-1:0] r_p;
    logic [SW-1:0] r_lsq;
    logic [csu_pkg::RBits-1:0] r_r;
    logic [TW-1:0] r_t2;
    logic [QW-1:0] r_acc;
    logic [csu_pkg::RBits-1:0] w_trial;
    logic [csu_pkg::RBits+1:0] w_t;
    logic [2*AccW-1:0] w_msq;
    logic [NormW-1:0] w_plo, w_phi;
    logic signed [AccW-1:0] r_sd;
    logic signed [SimW_L-1:0] r_sim;

    assign w_trial = r_r | (csu_pkg::RBits'(1) << (csu_pkg::RBits - 1 - int'(i_bit)));
    assign w_t = {1'b0, w_trial, 1'b0} - (csu_pkg::RBits+2)'(1);
    assign w_msq = (2*AccW)'(r_mag) * (2*AccW)'(r_mag);
    assign w_plo = r_p[NormW-1:0];
    assign w_phi = r_p[PW-1:NormW];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sd <= n_dot[AccW-1:0];
            r_sa <= n_na[NormW-1:0];
            r_sb <= n_nb[NormW-1:0];
        end
    end

    // Stage sequence: start captures the sums; prep forms na*nb and |dot|; then per
    // bit: square the trial, multiply it by the low and high halves of na*nb, compare.
    logic r_prep;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep <= 1'b0;
        end else begin
            r_prep <= i_cmd.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_prep) begin
            r_p    <= PW'(r_sa) * PW'(r_sb);
            r_neg  <= r_sd[AccW-1];
            r_mag  <= r_sd[AccW-1] ? AccW'(-r_sd) : AccW'(r_sd);
            r_zero <= (r_sa == '0) || (r_sb == '0);
            r_r    <= '0;
        end else if (i_cmd.bit_step) begin
            r_t2  <= TW'(w_t) * TW'(w_t);
            if (int'(i_bit) == 0) r_lsq <= {w_msq, 32'b0};
        end else if (i_cmd.lo_step) begin
            r_acc <= QW'(r_t2) * QW'(w_plo);
        end else if (i_cmd.hi_step) begin
            r_acc <= r_acc + ((QW'(r_t2) * QW'(w_phi)) << NormW);
        end else if (i_cmd.cmp_step) begin
            if (r_lsq >= r_acc) r_r <= w_trial;
        end
        if (i_cmd.finish) begin
            // magnitude of one or more: clamp to +32767 or -32768
            if (r_zero) r_sim <= '0;
            else if (r_r[csu_pkg::RBits-1]) r_sim <= r_neg ? 16'sh8000 : 16'sh7FFF;
            else if (r_neg) r_sim <= SimW_L'(-{1'b0, r_r});
            else r_sim <= $signed(r_r);
        end
    end

    assign o_stat.zero = r_zero;
    assign o_sim = r_sim;
endmodule

// ===== rtl/csu_ctrl.sv =====
// Sequencer for the result search of the cosine similarity unit.
`timescale 1ns / 1ps
module csu_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_last_acc,
    input  logic                      i_out_taken,
    output csu_pkg::t_dp_cmd          o_cmd,
    output logic [csu_pkg::CntW-1:0]  o_bit,
    output logic                      o_busy,
    output logic                      o_out_valid
);
    localparam logic [2:0] S_IDLE = 3'd0, S_PREP = 3'd1, S_MUL = 3'd2,
                           S_CMP = 3'd3, S_FIN = 3'd4, S_OUT = 3'd5,
                           S_MLO = 3'd6, S_MHI = 3'd7;
    logic [2:0] r_state, n_state;
    logic [csu_pkg::CntW-1:0] r_bit, n_bit;

    always_comb begin
        n_state = r_state;
        n_bit = r_bit;
        o_cmd = '0;
        o_cmd.start = i_last_acc;
        unique case (r_state)
            S_IDLE: if (i_last_acc) n_state = S_PREP;
            S_PREP: begin n_state = S_MUL; n_bit = '0; end
            S_MUL: begin o_cmd.bit_step = 1'b1; n_state = S_MLO; end
            S_MLO: begin o_cmd.lo_step = 1'b1; n_state = S_MHI; end
            S_MHI: begin o_cmd.hi_step = 1'b1; n_state = S_CMP; end
            S_CMP: begin
                o_cmd.cmp_step = 1'b1;
                if (int'(r_bit) == csu_pkg::RBits - 1) n_state = S_FIN;
                else begin n_bit = r_bit + 1'b1; n_state = S_MUL; end
            end
            S_FIN: begin o_cmd.finish = 1'b1; n_state = S_OUT; end
            S_OUT: if (i_out_taken) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_bit <= '0;
        end else begin
            r_state <= n_state; r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;
    assign o_busy = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_bit) < csu_pkg::RBits) else $error("bit index overrun");
    a_fin_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_out_valid) else $error("finish without result");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.bit_step, o_cmd.lo_step, o_cmd.hi_step, o_cmd.cmp_step,
                  o_cmd.finish}))
        else $error("datapath commands overlap");
endmodule

// ===== rtl/cosine_similarity_unit.sv =====
// Top level of the streaming cosine similarity unit.
`timescale 1ns / 1ps
// Cosine similarity of two signed 8-bit vectors streamed one element pair per beat.
// Input channel: i_elem_a, i_elem_b, i_last with i_valid / o_ready. Each beat adds
// a*b, a*a and b*b to saturating running sums.
// Output channel: o_similarity (signed Q1.15), o_zero_norm with o_valid / i_ready.
// One result follows each beat with i_last high; then the sums clear.
// Throughput: non-last beats are taken once per cycle. The last beat starts a
// bit-serial rounding search of 16 steps, preceded by a prep state; each step squares
// the trial value, multiplies it by the low and then the high half of na*nb and
// compares against |dot|^2*2^32, and a finish state forms the result. Input stalls
// from the last beat until the result beat is taken; the next beat can be taken in
// the cycle after that.
// Reset (synchronous, active low) clears the sums and the sequencer.
// A stalled receiver holds the result steady until it takes it.
module cosine_similarity_unit #(
    parameter int MAX_DIM = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [csu_pkg::ElemW-1:0]   i_elem_a,
    input  logic signed [csu_pkg::ElemW-1:0]   i_elem_b,
    input  logic                               i_last,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [csu_pkg::SimW-1:0]    o_similarity,
    output logic                               o_zero_norm
);
    localparam int AccLim = MAX_DIM * 16384;
    localparam int NormW = $clog2(AccLim + 1);
    localparam int AccW = NormW + 1;

    csu_pkg::t_dp_cmd w_cmd;
    csu_pkg::t_dp_stat w_stat;
    logic [csu_pkg::CntW-1:0] w_bit;
    logic w_busy, w_acc, w_last_acc;

    assign o_ready = !w_busy;
    assign w_acc = i_valid && o_ready;
    assign w_last_acc = w_acc && i_last;

    csu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_last_acc(w_last_acc),
        .i_out_taken(i_ready), .o_cmd(w_cmd), .o_bit(w_bit),
        .o_busy(w_busy), .o_out_valid(o_valid)
    );

    csu_datapath #(.AccW(AccW), .NormW(NormW), .AccLim(AccLim)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc_en(w_acc), .i_acc_last(i_last),
        .i_a(i_elem_a), .i_b(i_elem_b), .i_cmd(w_cmd), .i_bit(w_bit),
        .o_stat(w_stat), .o_sim(o_similarity)
    );

    assign o_zero_norm = w_stat.zero;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while result pending");
    a_zero_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_norm) |-> (o_similarity == '0))
        else $error("zero norm with nonzero similarity");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the streaming cosine similarity unit.
`timescale 1ns / 1ps
module tb;
    localparam int MaxDim   = 512;
    localparam longint AccLimit = longint'(MaxDim) * 16384;
    localparam int CycleLimit = 1500000;
    localparam int DrainWait  = 80;

    // traffic shapes for the idling phases
    typedef enum int {MODE_FREE, MODE_TX_IDLE, MODE_RX_STALL, MODE_BOTH} t_mode;

    typedef struct {
        logic signed [csu_pkg::ElemW-1:0] a;
        logic signed [csu_pkg::ElemW-1:0] b;
        logic                             last;
    } t_pair;

    typedef struct {
        logic signed [csu_pkg::SimW-1:0] sim;
        logic                            zero;
    } t_sim;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic signed [csu_pkg::ElemW-1:0] i_elem_a = '0;
    logic signed [csu_pkg::ElemW-1:0] i_elem_b = '0;
    logic i_last = 1'b0;
    logic o_ready, o_valid, o_zero_norm;
    logic signed [csu_pkg::SimW-1:0] o_similarity;

    t_pair pending_pairs[$];
    t_sim  sim_expected[$];
    t_mode mode = MODE_FREE;
    logic  took_pair = 1'b0;
    logic  hold_go = 1'b0;
    int    hold_cnt = 0;
    int    cycles = 0;
    int    mismatches = 0;

    // predictor copy of the running sums
    longint dot_acc = 0;
    longint na_acc = 0;
    longint nb_acc = 0;

    cosine_similarity_unit #(.MAX_DIM(MaxDim)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_elem_a(i_elem_a), .i_elem_b(i_elem_b), .i_last(i_last),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_similarity(o_similarity), .o_zero_norm(o_zero_norm)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clamp_sum(longint v);
        if (v > AccLimit) return AccLimit;
        if (v < -AccLimit) return -AccLimit;
        return v;
    endfunction

    // Exact rounded Q1.15 cosine: largest r with |d|*2^15/sqrt(p) + 0.5 >= r.
    function automatic t_sim cosine_q15(longint d, longint na, longint nb);
        t_sim res;
        logic [127:0] lhs, p, t, lo, hi, mid;
        logic neg;
        res.zero = 1'b0;
        if (na == 0 || nb == 0) begin
            res.sim = '0;
            res.zero = 1'b1;
            return res;
        end
        neg = d < 0;
        lhs = 128'(neg ? -d : d) << 16;
        lhs = lhs * lhs;
        p = 128'(na) * 128'(nb);
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            t = 2 * mid - 1;
            if (lhs >= t * t * p) lo = mid;
            else hi = mid - 1;
        end
        if (neg) res.sim = (csu_pkg::SimW)'(-lo);
        else res.sim = (lo > 32767) ? 16'sd32767 : (csu_pkg::SimW)'(lo);
        return res;
    endfunction

    function automatic logic signed [csu_pkg::ElemW-1:0] pick_elem();
        case ($urandom_range(0, 9))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return 8'sd0;
            default: return (csu_pkg::ElemW)'($urandom);
        endcase
    endfunction

    task automatic push_pair(int a, int b, bit last);
        t_pair p;
        p.a = (csu_pkg::ElemW)'(a);
        p.b = (csu_pkg::ElemW)'(b);
        p.last = last;
        pending_pairs.push_back(p);
    endtask

    // kind 0: independent, 1: b follows a, 2: b opposes a, 3: a is all zero
    task automatic push_vector(int len, int kind);
        logic signed [csu_pkg::ElemW-1:0] a, b;
        for (int k = 0; k < len; k++) begin
            a = pick_elem();
            b = pick_elem();
            case (kind)
                1: b = a;
                2: b = (a == -8'sd128) ? 8'sd127 : -a;
                3: a = 0;
                default: ;
            endcase
            push_pair(a, b, k == len - 1);
        end
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || sim_expected.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Input driver: advance to the next pair once the current beat is taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || took_pair)) begin
            if (pending_pairs.size() != 0 &&
                !((mode == MODE_TX_IDLE && chance(86)) || (mode == MODE_BOTH && chance(12)))) begin
                t_pair p;
                p = pending_pairs.pop_front();
                i_elem_a <= p.a;
                i_elem_b <= p.b;
                i_last   <= p.last;
                i_valid  <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver ready: drop it during a hold-off, else stall per phase.
    always @(negedge i_clk) begin
        if (hold_cnt > 0) i_ready <= 1'b0;
        else if (mode == MODE_RX_STALL) i_ready <= !chance(86);
        else if (mode == MODE_BOTH) i_ready <= !chance(12);
        else i_ready <= 1'b1;
    end

    // Long receiver hold-off, counted here so the sender keeps offering beats.
    always @(posedge i_clk) begin
        if (hold_go && hold_cnt == 0) hold_cnt <= 400;
        else if (hold_cnt > 1) hold_cnt <= hold_cnt - 1;
        else if (hold_cnt == 1 && !hold_go) hold_cnt <= 0;
    end

    // Input monitor: fold each accepted beat into the predicted sums.
    always @(posedge i_clk) begin
        took_pair <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            dot_acc = clamp_sum(dot_acc + longint'(i_elem_a) * longint'(i_elem_b));
            na_acc  = clamp_sum(na_acc + longint'(i_elem_a) * longint'(i_elem_a));
            nb_acc  = clamp_sum(nb_acc + longint'(i_elem_b) * longint'(i_elem_b));
            if (i_last) begin
                sim_expected.push_back(cosine_q15(dot_acc, na_acc, nb_acc));
                dot_acc = 0;
                na_acc = 0;
                nb_acc = 0;
            end
        end
    end

    // Output monitor: compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (sim_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: sim %0d zero %0b",
                             o_similarity, o_zero_norm);
            end else begin
                t_sim e;
                e = sim_expected.pop_front();
                if (e.sim !== o_similarity || e.zero !== o_zero_norm) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp sim %0d zero %0b, got sim %0d zero %0b",
                                 e.sim, e.zero, o_similarity, o_zero_norm);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, saturation at plus and minus one, zero norms
        push_pair(127, 127, 1);
        push_pair(-128, -128, 1);
        push_pair(-128, 127, 1);
        push_pair(127, -128, 1);
        push_pair(0, 5, 1);
        push_pair(7, 0, 1);
        push_pair(0, 0, 1);
        push_pair(1, 0, 0);
        push_pair(0, 1, 1);
        push_pair(3, 4, 0);
        push_pair(4, -3, 1);
        push_pair(-1, -1, 0);
        push_pair(1, 1, 0);
        push_pair(-128, 127, 1);
        push_pair(1, 127, 0);
        push_pair(127, 1, 1);
        push_pair(-1, 1, 1);
        push_pair(100, 99, 0);
        push_pair(-50, -51, 1);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            mode = t_mode'(ph);
            for (int v = 0; v < 38; v++)
                push_vector(chance(85) ? $urandom_range(1, 6) : $urandom_range(7, 24),
                            chance(70) ? 0 : $urandom_range(1, 3));
            if (ph == 0) begin
                // fill the block while the receiver holds off
                hold_go = 1'b1;
                repeat (500) @(posedge i_clk);
                hold_go = 1'b0;
            end
            // sender pauses here until every result is in
            wait_idle();
        end

        // overlong vector drives the dot sum and both norms into saturation
        mode = MODE_FREE;
        for (int k = 0; k < 520; k++) push_pair(-128, 127, 0);
        push_pair(1, 127, 1);
        wait_idle();

        if (mismatches == 0 && sim_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/csu_pkg.sv
rtl/csu_datapath.sv
rtl/csu_ctrl.sv
rtl/cosine_similarity_unit.sv
tb/tb.sv
